// ----- rtl/slcd_pkg.sv -----
package slcd_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;

    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SKIP_W     = 4;
    localparam int MAX_W      = 16;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hA5;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_READY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_SKIP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA      = 2'd3;

    localparam logic [BYTE_W-1:0] RST_EXPECTED_TYPE = 8'h44;
    localparam logic [SKIP_W-1:0] RST_PREFIX_SKIP   = 4'd4;
    localparam logic [MAX_W-1:0]  RST_MAX_DATA      = 16'd512;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_START  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRONG_TYPE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd4;

    typedef struct packed {
        logic               link_ready;
        logic [BYTE_W-1:0]  expected_type;
        logic [SKIP_W-1:0]  prefix_skip;
        logic [MAX_W-1:0]   max_data;
    } t_cfg;

    typedef struct packed {
        logic                is_status;
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// ----- rtl/slcd_rx_if.sv -----
interface slcd_rx_if;
    logic                        valid;
    logic                        ready;
    logic [slcd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/slcd_res_if.sv -----
interface slcd_res_if;
    logic                          valid;
    logic                          ready;
    logic                          is_status;
    logic [slcd_pkg::BYTE_W-1:0]   data_byte;
    logic [slcd_pkg::STATUS_W-1:0] status;

    modport source (output valid, output is_status, output data_byte, output status,
                    input ready);
    modport sink (input valid, input is_status, input data_byte, input status,
                  output ready);
endinterface

// ----- rtl/slcd_cfg_regs.sv -----
module slcd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slcd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output slcd_pkg::t_cfg                    o_cfg,
    output logic                              o_link_drop
);
    import slcd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg       = r_cfg;
        o_link_drop = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINK_READY: begin
                    n_cfg.link_ready = i_cfg_data[0];
                    o_link_drop      = ~i_cfg_data[0];
                end
                CFG_EXPECTED_TYPE: n_cfg.expected_type = i_cfg_data[BYTE_W-1:0];
                CFG_PREFIX_SKIP:   n_cfg.prefix_skip   = i_cfg_data[SKIP_W-1:0];
                CFG_MAX_DATA:      n_cfg.max_data      = i_cfg_data[MAX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_ready    <= 1'b0;
            r_cfg.expected_type <= RST_EXPECTED_TYPE;
            r_cfg.prefix_skip   <= RST_PREFIX_SKIP;
            r_cfg.max_data      <= RST_MAX_DATA;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/slcd_parser.sv -----
module slcd_parser #(
    parameter int LENGTH_WIDTH = slcd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slcd_pkg::t_cfg                i_cfg,
    input  logic                          i_link_drop,
    input  logic                          i_take,
    input  logic [slcd_pkg::BYTE_W-1:0]   i_byte,
    output logic                          o_push,
    output slcd_pkg::t_result             o_result
);
    import slcd_pkg::*;

    localparam int CMP_W = ((LENGTH_WIDTH > MAX_W) ? LENGTH_WIDTH : MAX_W) + 1;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_TYPE    = 6'b000010,
        PH_LEN_HI  = 6'b000100,
        PH_LEN_LO  = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [BYTE_W-1:0]       r_sum, n_sum;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [LENGTH_WIDTH-1:0] r_cnt, n_cnt;

    logic [BYTE_W-1:0]       w_sum_b;
    logic [CMP_W-1:0]        w_cnt, w_skip, w_max, w_len, w_cnt_inc;
    logic [LENGTH_WIDTH-1:0] w_len_lo;
    logic                    w_emit;

    assign w_sum_b   = r_sum + i_byte;
    assign w_cnt     = CMP_W'(r_cnt);
    assign w_skip    = CMP_W'(i_cfg.prefix_skip);
    assign w_max     = CMP_W'(i_cfg.max_data);
    assign w_len     = CMP_W'(r_len);
    assign w_cnt_inc = w_cnt + CMP_W'(1);
    assign w_len_lo  = r_len | LENGTH_WIDTH'(i_byte);
    assign w_emit    = (w_cnt >= w_skip) && ((w_cnt - w_skip) < w_max);

    always_comb begin
        n_phase  = r_phase;
        n_sum    = r_sum;
        n_len    = r_len;
        n_cnt    = r_cnt;
        o_push   = 1'b0;
        o_result = '0;
        if (i_link_drop) begin
            n_phase = PH_IDLE;
            n_sum   = '0;
            n_len   = '0;
            n_cnt   = '0;
        end else if (i_take && i_cfg.link_ready) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte == SYNC_BYTE) begin
                        n_phase = PH_TYPE;
                        n_sum   = '0;
                        n_len   = '0;
                        n_cnt   = '0;
                    end else begin
                        o_push             = 1'b1;
                        o_result.is_status = 1'b1;
                        o_result.status    = ST_BAD_START;
                    end
                end
                PH_TYPE: begin
                    if (i_byte != i_cfg.expected_type) begin
                        n_phase            = PH_IDLE;
                        n_sum              = '0;
                        n_len              = '0;
                        n_cnt              = '0;
                        o_push             = 1'b1;
                        o_result.is_status = 1'b1;
                        o_result.status    = ST_WRONG_TYPE;
                    end else begin
                        n_sum   = i_byte;
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_sum   = w_sum_b;
                    n_len   = LENGTH_WIDTH'({i_byte, 8'h00});
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_sum   = w_sum_b;
                    n_len   = w_len_lo;
                    n_cnt   = '0;
                    n_phase = (w_len_lo == '0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    n_sum = w_sum_b;
                    if (w_emit) begin
                        o_push             = 1'b1;
                        o_result.data_byte = i_byte;
                    end
                    n_cnt = w_cnt_inc[LENGTH_WIDTH-1:0];
                    if (w_cnt_inc >= w_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    o_push             = 1'b1;
                    o_result.is_status = 1'b1;
                    priority if (w_len < w_skip) begin
                        o_result.status = ST_TOO_SHORT;
                    end else if (w_sum_b != '0) begin
                        o_result.status = ST_MISMATCH;
                    end else begin
                        o_result.status = ST_OK;
                    end
                    n_phase = PH_IDLE;
                    n_sum   = '0;
                    n_len   = '0;
                    n_cnt   = '0;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_sum   = '0;
                    n_len   = '0;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sum   <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/slcd_out_fifo.sv -----
module slcd_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  slcd_pkg::t_result   i_result,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output slcd_pkg::t_result   o_result
);
    import slcd_pkg::*;

    t_result    r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_full   = (r_count == 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign o_result = r_mem[r_rptr];
    assign w_pop    = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(w_pop);
        end
    end

endmodule

// ----- rtl/sync_length_checksum_deframer_top.sv -----
// Each result is registered in the result buffer before it is presented.
// Throughput: one byte per cycle unless the result buffer is full.
// A two-entry result buffer lets input continue while one result waits at the output.
// Reset: synchronous, active low; clears the parser to idle, empties the result
// buffer and loads register defaults (link not ready, type 0x44, skip 4, max 512).
module sync_length_checksum_deframer_top #(
    parameter int LENGTH_WIDTH = slcd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    slcd_rx_if.sink                         i_rx,
    slcd_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [slcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slcd_pkg::*;

    t_cfg    w_cfg;
    logic    w_link_drop;
    logic    w_take;
    logic    w_push;
    logic    w_full;
    t_result w_push_res;
    t_result w_out_res;

    assign i_rx.ready = ~w_full;
    assign w_take     = i_rx.valid && ~w_full;

    slcd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_link_drop (w_link_drop)
    );

    slcd_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_link_drop (w_link_drop),
        .i_take      (w_take),
        .i_byte      (i_rx.rx_byte),
        .o_push      (w_push),
        .o_result    (w_push_res)
    );

    slcd_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_result (w_push_res),
        .o_full   (w_full),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (w_out_res)
    );

    assign o_res.is_status = w_out_res.is_status;
    assign o_res.data_byte = w_out_res.data_byte;
    assign o_res.status    = w_out_res.status;

endmodule

// ----- rtl/slcd_checker.sv -----
module slcd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_is_status,
    input logic [slcd_pkg::BYTE_W-1:0]   i_data_byte,
    input logic [slcd_pkg::STATUS_W-1:0] i_status
);
    import slcd_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_is_status)
            && $stable(i_data_byte) && $stable(i_status))
        else $error("result changed while stalled");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_is_status |-> i_status == ST_OK)
        else $error("data result carries a status code");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_is_status |-> i_data_byte == '0
            && (i_status == ST_OK || i_status == ST_BAD_START || i_status == ST_WRONG_TYPE
                || i_status == ST_TOO_SHORT || i_status == ST_MISMATCH))
        else $error("malformed status result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind sync_length_checksum_deframer_top slcd_checker u_slcd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_is_status (o_res.is_status),
    .i_data_byte (o_res.data_byte),
    .i_status    (o_res.status)
);
